FILE: sv/button_press_hold_release_events_top_assert.svh
// assertion macros for the button event classifier
`ifndef BUTTON_PRESS_HOLD_RELEASE_EVENTS_TOP_ASSERT_SVH
`define BUTTON_PRESS_HOLD_RELEASE_EVENTS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BPE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpe assertion failed");
// next-cycle implication
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpe assertion failed");
`else
`define BPE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/bpe_pkg.sv
// shared constants and types for the button event classifier
`default_nettype none

package bpe_pkg;

   // button count and derived widths
   localparam int NumButtons = 7;
   localparam int IdxW = (NumButtons > 1) ? $clog2(NumButtons) : 1;
   localparam int CntW = $clog2(NumButtons + 1);

   // payload field widths
   localparam int BtnW = 3;
   localparam int KindW = 2;
   localparam int DurW = 32;
   localparam int ThrW = 16;

   // event kinds
   localparam logic [KindW-1:0] KindPress = 2'd0;
   localparam logic [KindW-1:0] KindRelease = 2'd1;
   localparam logic [KindW-1:0] KindHold = 2'd2;

   // register file
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam int CsrIdxW = CsrAddrW - 2;
   localparam logic [CsrIdxW-1:0] RegHoldThr = 1'b0;
   localparam logic [ThrW-1:0] ThrReset = 16'd800;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // one result
   typedef struct packed {
      logic [BtnW-1:0] button;
      logic [KindW-1:0] kind;
      logic [DurW-1:0] duration;
   } event_type;

endpackage

`default_nettype wire

FILE: sv/bpe_ifs.sv
// request and response channel interfaces
`default_nettype none

interface bpe_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [bpe_pkg::BtnW-1:0] button_index;
   logic pin_level;

   modport source(output valid, action, button_index, pin_level, input ready);
   modport sink(input valid, action, button_index, pin_level, output ready);
endinterface

interface bpe_rsp_if;
   logic valid;
   logic ready;
   logic [bpe_pkg::BtnW-1:0] event_button;
   logic [bpe_pkg::KindW-1:0] event_kind;
   logic [bpe_pkg::DurW-1:0] elapsed_ms;
   logic last_event;

   modport source(output valid, event_button, event_kind, elapsed_ms, last_event,
                  input ready);
   modport sink(input valid, event_button, event_kind, elapsed_ms, last_event,
                output ready);
endinterface

`default_nettype wire

FILE: sv/button_press_hold_release_events_top.sv
// Button event classifier: a level report is registered on acceptance, then its result, if any,
// is registered from the LEVEL state; the next transaction is taken back in IDLE. A tick walks
// all NumButtons entries through the single read port of the press-time memory, one per
// cycle, and its final hold, if any, is sent from the FLUSH state before the return to IDLE;
// a full result register stalls the sequencer.
// Reset is synchronous: time, flags and sequencer clear, threshold returns to 800.
`default_nettype none

module button_press_hold_release_events_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bpe_req_if.sink                             req_bus,
   bpe_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [bpe_pkg::CsrAddrW-1:0]   csr_paddr,
   input  wire logic [bpe_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic      [bpe_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import bpe_pkg::*;

   `include "button_press_hold_release_events_top_assert.svh"

   // control registers
   state_type state_ff, state_in;
   logic [DurW-1:0] time_ff, time_in;
   logic [ThrW-1:0] thr_ff, thr_in;
   logic [NumButtons-1:0] is_down_ff, is_down_in;
   logic [NumButtons-1:0] hold_done_ff, hold_done_in;
   logic [CntW-1:0] scan_cnt_ff, scan_cnt_in;
   logic eval_valid_ff, eval_valid_in;
   logic pend_valid_ff, pend_valid_in;
   logic out_valid_ff, out_valid_in;

   // payload registers
   logic [BtnW-1:0] b_ff, b_in;
   logic level_ff, level_in;
   logic [IdxW-1:0] eval_idx_ff, eval_idx_in;
   event_type pend_ff, pend_in;
   event_type out_ff, out_in;
   logic out_last_ff, out_last_in;

   // press-time memory, not cleared: an entry's value is used only while
   // its button is down, and the press wrote it
   logic [DurW-1:0] press_mem [NumButtons];
   logic [DurW-1:0] rd_data_ff;
   logic rd_en;
   logic [IdxW-1:0] rd_addr;
   logic wr_en;
   logic [IdxW-1:0] wr_addr;

   // shared decode
   logic accept;
   logic out_free;
   logic lvl_in_range;
   logic [IdxW-1:0] b_idx;
   logic lvl_press;
   logic lvl_release;
   logic lvl_emit;
   logic [DurW-1:0] held;
   logic hit;
   logic stall;
   logic scan_done;
   logic csr_wr;
   logic [CsrIdxW-1:0] csr_idx;

   assign accept = req_bus.valid && req_bus.ready;
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign lvl_in_range = int'(b_ff) < NumButtons;
   assign b_idx = IdxW'(b_ff);
   assign lvl_press = lvl_in_range && !level_ff && !is_down_ff[b_idx];
   assign lvl_release = lvl_in_range && level_ff && is_down_ff[b_idx];
   assign lvl_emit = lvl_press || (lvl_release && !hold_done_ff[b_idx]);
   assign held = time_ff - rd_data_ff;
   assign hit = eval_valid_ff && is_down_ff[eval_idx_ff] && !hold_done_ff[eval_idx_ff]
                && (held >= DurW'(thr_ff));
   assign stall = hit && pend_valid_ff && !out_free;
   assign scan_done = !stall && !eval_valid_ff && (scan_cnt_ff == CntW'(NumButtons));

   // register port
   assign csr_idx = csr_paddr[CsrAddrW-1:2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_idx == RegHoldThr) ? CsrDataW'(thr_ff) : '0;
   assign thr_in = (csr_wr && (csr_idx == RegHoldThr)) ? csr_pwdata[ThrW-1:0] : thr_ff;

   // channel outputs
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.event_button = out_ff.button;
   assign rsp_bus.event_kind = out_ff.kind;
   assign rsp_bus.elapsed_ms = out_ff.duration;
   assign rsp_bus.last_event = out_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_bus.action ? ST_SCAN : ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            if (!lvl_emit || out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      time_in = time_ff;
      is_down_in = is_down_ff;
      hold_done_in = hold_done_ff;
      scan_cnt_in = scan_cnt_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in = eval_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      out_last_in = out_last_ff;
      b_in = b_ff;
      level_in = level_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = b_idx;

      // result drains
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.action) begin
                  time_in = time_ff + 1'b1;
                  scan_cnt_in = '0;
                  eval_valid_in = 1'b0;
               end else begin
                  b_in = req_bus.button_index;
                  level_in = req_bus.pin_level;
                  rd_en = int'(req_bus.button_index) < NumButtons;
                  rd_addr = IdxW'(req_bus.button_index);
               end
            end
         end
         ST_LEVEL: begin
            // press or release, once the result register has room
            if (lvl_press && out_free) begin
               wr_en = 1'b1;
               is_down_in[b_idx] = 1'b1;
               hold_done_in[b_idx] = 1'b0;
               out_valid_in = 1'b1;
               out_in = '{button: b_ff, kind: KindPress, duration: '0};
               out_last_in = 1'b1;
            end else if (lvl_release && hold_done_ff[b_idx]) begin
               is_down_in[b_idx] = 1'b0;
            end else if (lvl_release && out_free) begin
               is_down_in[b_idx] = 1'b0;
               out_valid_in = 1'b1;
               out_in = '{button: b_ff, kind: KindRelease, duration: held};
               out_last_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               // hold found: older pending one goes out as not last
               if (hit) begin
                  hold_done_in[eval_idx_ff] = 1'b1;
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in = pend_ff;
                     out_last_in = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_in = '{button: BtnW'(eval_idx_ff), kind: KindHold, duration: held};
               end
               // issue the next memory read
               if (scan_cnt_ff < CntW'(NumButtons)) begin
                  rd_en = 1'b1;
                  rd_addr = scan_cnt_ff[IdxW-1:0];
                  eval_idx_in = scan_cnt_ff[IdxW-1:0];
                  eval_valid_in = 1'b1;
                  scan_cnt_in = scan_cnt_ff + 1'b1;
               end else begin
                  eval_valid_in = 1'b0;
               end
            end
         end
         ST_FLUSH: begin
            // final hold of the tick carries the last flag
            if (pend_valid_ff && out_free) begin
               out_valid_in = 1'b1;
               out_in = pend_ff;
               out_last_in = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         time_ff <= '0;
         thr_ff <= ThrReset;
         is_down_ff <= '0;
         hold_done_ff <= '0;
         scan_cnt_ff <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         time_ff <= time_in;
         thr_ff <= thr_in;
         is_down_ff <= is_down_in;
         hold_done_ff <= hold_done_in;
         scan_cnt_ff <= scan_cnt_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      b_ff <= b_in;
      level_ff <= level_in;
      eval_idx_ff <= eval_idx_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
      out_last_ff <= out_last_in;
   end

   // press-time memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         press_mem[wr_addr] <= time_ff;
      end
      if (rd_en) begin
         rd_data_ff <= press_mem[rd_addr];
      end
   end

   // checks
   `BPE_ASSERT_IMPLIES(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_valid_ff)
   `BPE_ASSERT_IMPLIES(a_hold_marked, clock, reset,
                       out_valid_ff && out_ff.kind == KindHold,
                       hold_done_ff[IdxW'(out_ff.button)])
   `BPE_ASSERT_IMPLIES(a_not_last_mid_tick, clock, reset, out_valid_ff && !out_last_ff,
                       state_ff == ST_SCAN || state_ff == ST_FLUSH)
   `BPE_ASSERT_NEXT(a_level_result, clock, reset,
                    state_ff == ST_LEVEL && lvl_emit && out_free,
                    out_valid_ff && out_last_ff)

endmodule

`default_nettype wire

FILE: tb/button_press_hold_release_events_top_test.sv
// self-checking testbench for the button press, hold and release event classifier
module button_press_hold_release_events_top_test;
   import bpe_pkg::*;

   // input codes and test constants
   localparam logic ActLevel = 1'b0;
   localparam logic ActTick = 1'b1;
   localparam logic LevelDown = 1'b0;
   localparam logic LevelUp = 1'b1;
   localparam logic [BtnW-1:0] IdxBeyond = 3'd7;
   localparam logic [CsrIdxW-1:0] RegSpare = 1'b1;
   localparam int MaxEvents = 7;
   localparam int DrainCycles = 40;
   localparam int IdlePercent = 8;
   localparam int PhaseItems = 68;
   localparam int NumPhases = 6;

   typedef struct packed {
      logic action;
      logic [BtnW-1:0] index;
      logic level;
   } button_item_type;

   typedef struct packed {
      logic [BtnW-1:0] button;
      logic [KindW-1:0] kind;
      logic [DurW-1:0] duration;
      logic last;
   } event_rec_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic csr_pready;

   bpe_req_if req_bus();
   bpe_rsp_if rsp_bus();

   button_press_hold_release_events_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // stimulus backlog and expected events
   button_item_type item_backlog[$];
   event_rec_type pending_events[$];
   button_item_type next_item;
   button_item_type taken_item;
   event_rec_type want;
   event_rec_type got;

   // shadow copy of the classifier state
   logic [DurW-1:0] now_ms;
   logic [DurW-1:0] pressed_at[NumButtons];
   logic [NumButtons-1:0] is_pressed;
   logic [NumButtons-1:0] hold_latched;
   logic [ThrW-1:0] hold_limit;

   // button levels as planned by the stimulus
   logic [NumButtons-1:0] plan_down;

   bit calm;
   int error_count;
   int items_taken;
   int events_seen;
   int press_count;
   int release_count;
   int hold_count;

   // work out the events one accepted transaction causes
   function automatic void classify_button_item(input button_item_type item);
      event_rec_type batch[MaxEvents];
      logic [DurW-1:0] held;
      int n;
      n = 0;
      if (item.action == ActLevel) begin
         if (item.index < NumButtons) begin
            if (item.level == LevelDown && !is_pressed[item.index]) begin
               is_pressed[item.index] = 1'b1;
               hold_latched[item.index] = 1'b0;
               pressed_at[item.index] = now_ms;
               batch[n] = {item.index, KindPress, {DurW{1'b0}}, 1'b0};
               n++;
            end else if (item.level == LevelUp && is_pressed[item.index]) begin
               is_pressed[item.index] = 1'b0;
               // a release after a fired hold stays silent
               if (!hold_latched[item.index]) begin
                  batch[n] = {item.index, KindRelease, now_ms - pressed_at[item.index], 1'b0};
                  n++;
               end
            end
         end
      end else begin
         now_ms = now_ms + 1'b1;
         for (int b = 0; b < NumButtons && n < MaxEvents; b++) begin
            held = now_ms - pressed_at[b];
            if (is_pressed[b] && !hold_latched[b] && held >= hold_limit) begin
               hold_latched[b] = 1'b1;
               batch[n] = {b[BtnW-1:0], KindHold, held, 1'b0};
               n++;
            end
         end
      end
      if (n > 0) begin
         batch[n-1].last = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         pending_events.push_back(batch[k]);
      end
   endfunction

   // queue one transaction and track the planned level
   function automatic void push_item(input logic act, input logic [BtnW-1:0] idx,
                                     input logic lvl);
      button_item_type it;
      it.action = act;
      it.index = idx;
      it.level = lvl;
      item_backlog.push_back(it);
      if (act == ActLevel && idx < NumButtons) begin
         plan_down[idx] = (lvl == LevelDown);
      end
   endfunction

   // mostly clean press/tick/release traffic, some noise
   function automatic void queue_random_items(input int count);
      int pick;
      logic [BtnW-1:0] b;
      repeat (count) begin
         pick = $urandom_range(99);
         b = BtnW'($urandom_range(NumButtons - 1));
         if (pick < 55) begin
            push_item(ActTick, BtnW'($urandom_range(7)), 1'($urandom_range(1)));
         end else if (pick < 93) begin
            push_item(ActLevel, b, plan_down[b] ? LevelUp : LevelDown);
         end else if (pick < 96) begin
            push_item(ActLevel, IdxBeyond, 1'($urandom_range(1)));
         end else begin
            push_item(ActLevel, b, plan_down[b] ? LevelDown : LevelUp);
         end
      end
   endfunction

   // wait until nothing is queued, in flight or expected for a while
   task automatic settle();
      int quiet;
      quiet = 0;
      while (quiet < DrainCycles) begin
         @(posedge clock);
         if (item_backlog.size() != 0 || req_bus.valid || pending_events.size() != 0) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
   endtask

   // register write, setup then access phase
   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == RegHoldThr) begin
         hold_limit = data[ThrW-1:0];
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // read the hold threshold back and compare
   task automatic check_threshold();
      logic [CsrDataW-1:0] value;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {RegHoldThr, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (value !== {{(CsrDataW - ThrW){1'b0}}, hold_limit}) begin
         $display("%0t: threshold readback expected %0d got %0d", $time, hold_limit, value);
         error_count++;
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver: present queued transactions with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (item_backlog.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
            next_item = item_backlog.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.action <= next_item.action;
            req_bus.button_index <= next_item.index;
            req_bus.pin_level <= next_item.level;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: predict on accepted input, check each accepted event
   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= IdlePercent);
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken_item = {req_bus.action, req_bus.button_index, req_bus.pin_level};
            classify_button_item(taken_item);
            items_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.event_button, rsp_bus.event_kind, rsp_bus.elapsed_ms,
                   rsp_bus.last_event};
            if (pending_events.size() == 0) begin
               $display("%0t: unexpected event button %0d kind %0d duration %0d last %0b",
                        $time, got.button, got.kind, got.duration, got.last);
               error_count++;
            end else begin
               want = pending_events.pop_front();
               if (got.button !== want.button || got.kind !== want.kind ||
                   got.duration !== want.duration || got.last !== want.last) begin
                  $display("%0t: mismatch expected button %0d kind %0d duration %0d last %0b",
                           $time, want.button, want.kind, want.duration, want.last);
                  $display("%0t:               got button %0d kind %0d duration %0d last %0b",
                           $time, got.button, got.kind, got.duration, got.last);
                  error_count++;
               end
               events_seen++;
               case (want.kind)
                  KindPress: press_count++;
                  KindRelease: release_count++;
                  KindHold: hold_count++;
                  default: ;
               endcase
            end
         end
      end
   end

   // run limit
   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

   // stimulus sequence
   initial begin
      int thresholds[NumPhases];
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = 1'b0;
      req_bus.button_index = '0;
      req_bus.pin_level = 1'b1;
      rsp_bus.ready = 1'b0;
      now_ms = '0;
      foreach (pressed_at[i]) pressed_at[i] = '0;
      is_pressed = '0;
      hold_latched = '0;
      plan_down = '0;
      hold_limit = ThrReset;
      calm = 1'b0;
      error_count = 0;
      items_taken = 0;
      events_seen = 0;
      press_count = 0;
      release_count = 0;
      hold_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_threshold();

      // press, a few ticks below the reset threshold, release
      push_item(ActLevel, 3'd0, LevelDown);
      repeat (3) push_item(ActTick, 3'd0, LevelUp);
      push_item(ActLevel, 3'd0, LevelUp);
      // repeated level and out-of-range button are ignored
      push_item(ActLevel, 3'd0, LevelUp);
      push_item(ActLevel, IdxBeyond, LevelDown);
      push_item(ActLevel, IdxBeyond, LevelUp);
      push_item(ActLevel, 3'd6, LevelDown);
      push_item(ActLevel, 3'd6, LevelDown);
      settle();

      // write to a register that does not exist, then a zero threshold
      csr_write(RegSpare, 32'h0000_ffff);
      check_threshold();
      csr_write(RegHoldThr, 32'd0);
      check_threshold();
      // level reports never fire holds, the next tick does
      push_item(ActLevel, 3'd1, LevelDown);
      push_item(ActLevel, 3'd2, LevelDown);
      push_item(ActTick, 3'd7, LevelDown);
      // releases after a fired hold stay silent
      push_item(ActLevel, 3'd1, LevelUp);
      push_item(ActLevel, 3'd2, LevelUp);
      push_item(ActLevel, 3'd6, LevelUp);
      settle();

      // all buttons reach the threshold on one tick
      csr_write(RegHoldThr, 32'd2);
      check_threshold();
      for (int b = 0; b < NumButtons; b++) begin
         push_item(ActLevel, b[BtnW-1:0], LevelDown);
      end
      push_item(ActTick, 3'd5, LevelUp);
      push_item(ActTick, 3'd2, LevelDown);

      // random phases, each under its own threshold
      thresholds = '{1, 65535, 0, 0, 5, 0};
      thresholds[2] = $urandom_range(12, 2);
      thresholds[3] = $urandom_range(65535, 1);
      thresholds[5] = $urandom_range(20, 3);
      for (int p = 0; p < NumPhases; p++) begin
         settle();
         csr_write(RegHoldThr, thresholds[p]);
         check_threshold();
         calm <= (p == 4);
         queue_random_items(PhaseItems);
      end
      settle();

      $display("summary: %0d transactions, %0d events (%0d press, %0d release, %0d hold)",
               items_taken, events_seen, press_count, release_count, hold_count);
      $display("summary: thresholds 0, 1, 2, 65535 and random values, %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
